>>> rtl/core/snu_pkg.sv
// Shared types and constants for the surface normal unit.
`timescale 1ns / 1ps
`default_nettype none
package snu_pkg;

  localparam int NORM_BITS       = 24;
  localparam int SUM_WIDTH       = 2 * NORM_BITS + 2;
  localparam int ROOT_WIDTH      = NORM_BITS + 1;
  localparam int OUT_WIDTH       = 16;
  localparam int EDGE_LIMIT_BITS = 30;

  typedef struct packed {
    logic       deg;
    logic [2:0] neg;
  } snu_flags_t;

  typedef logic [NORM_BITS-1:0] snu_mag_t;

  typedef struct packed {
    snu_mag_t [2:0] mag;
    snu_flags_t     flags;
  } snu_side_t;

  // Width of the signed vector that feeds normalization.
  function automatic int vec_width(int cw);
    int ew;
    int lw;
    ew = cw + 1;
    lw = (ew > EDGE_LIMIT_BITS + 1) ? EDGE_LIMIT_BITS + 1 : ew;
    return 2 * lw + 1;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/snu_cross.sv
// Edge vectors, wide edge limiting and cross product, or the plain vector (four stages).
`timescale 1ns / 1ps
`default_nettype none
module snu_cross #(
  parameter int CW = 16,
  parameter int VW = 35
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic                   command,
  input  wire logic [2:0][CW-1:0]     a,
  input  wire logic [2:0][CW-1:0]     b,
  input  wire logic [2:0][CW-1:0]     c,
  output logic                        vec_valid,
  output logic [2:0][VW-1:0]          vec
);

  localparam int EW    = CW + 1;
  localparam int LW    = (EW > snu_pkg::EDGE_LIMIT_BITS + 1) ?
                         snu_pkg::EDGE_LIMIT_BITS + 1 : EW;
  localparam int PW    = 2 * LW;
  localparam int BLW   = $clog2(EW + 1);
  localparam int LIMIT = snu_pkg::EDGE_LIMIT_BITS;

  logic                         v1, v2, v3;
  logic                         cmd1, cmd2, cmd3;
  logic [2:0][CW-1:0]           a1, a2, a3;
  logic [1:0][2:0][EW-1:0]      ed1;
  logic [1:0][2:0][LW-1:0]      lim2;
  logic [5:0][PW-1:0]           p3;

  logic [1:0][2:0][EW-1:0]      emag;
  logic [1:0][EW-1:0]           eor;
  logic [1:0][BLW-1:0]          ebl;
  logic [1:0][BLW-1:0]          esh;
  logic [1:0][2:0][LW-1:0]      elim;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      vec_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      vec_valid <= v3;
    end
  end

  // stage 1: edges
  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= command;
      a1   <= a;
      for (int i = 0; i < 3; i++) begin
        ed1[0][i] <= EW'($signed(b[i])) - EW'($signed(a[i]));
        ed1[1][i] <= EW'($signed(c[i])) - EW'($signed(a[i]));
      end
    end
  end

  // wide edge limit
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      eor[k] = '0;
      for (int i = 0; i < 3; i++) begin
        emag[k][i] = ed1[k][i][EW-1] ? EW'(-ed1[k][i]) : ed1[k][i];
        eor[k]     = eor[k] | emag[k][i];
      end
      ebl[k] = '0;
      for (int j = 0; j < EW; j++) begin
        if (eor[k][j]) ebl[k] = BLW'(j + 1);
      end
      esh[k] = (int'(ebl[k]) > LIMIT) ? BLW'(int'(ebl[k]) - LIMIT) : '0;
      for (int i = 0; i < 3; i++) begin
        elim[k][i] = ed1[k][i][EW-1] ? LW'(~(emag[k][i] >> esh[k]) + 1'b1)
                                     : LW'(emag[k][i] >> esh[k]);
      end
    end
  end

  // stage 2
  always_ff @(posedge clk) begin
    if (en) begin
      cmd2 <= cmd1;
      a2   <= a1;
      lim2 <= elim;
    end
  end

  // stage 3: products
  always_ff @(posedge clk) begin
    if (en) begin
      cmd3  <= cmd2;
      a3    <= a2;
      p3[0] <= PW'($signed(lim2[0][1]) * $signed(lim2[1][2]));
      p3[1] <= PW'($signed(lim2[0][2]) * $signed(lim2[1][1]));
      p3[2] <= PW'($signed(lim2[0][2]) * $signed(lim2[1][0]));
      p3[3] <= PW'($signed(lim2[0][0]) * $signed(lim2[1][2]));
      p3[4] <= PW'($signed(lim2[0][0]) * $signed(lim2[1][1]));
      p3[5] <= PW'($signed(lim2[0][1]) * $signed(lim2[1][0]));
    end
  end

  // stage 4: differences or plain vector
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (cmd3) begin
          vec[i] <= VW'($signed(p3[2*i])) - VW'($signed(p3[2*i+1]));
        end else begin
          vec[i] <= VW'($signed(a3[i]));
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/snu_prenorm.sv
// Magnitudes, range normalization to 24 bits and sum of squares (five stages).
`timescale 1ns / 1ps
`default_nettype none
module snu_prenorm #(
  parameter int VW = 35
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                vec_valid,
  input  wire logic [2:0][VW-1:0]                  vec,
  output logic                                     sum_valid,
  output logic [snu_pkg::SUM_WIDTH-1:0]            sum,
  output snu_pkg::snu_side_t                       side
);

  localparam int NB  = snu_pkg::NORM_BITS;
  localparam int SW  = snu_pkg::SUM_WIDTH;
  localparam int BLW = $clog2(VW + 1);

  logic                      v1, v2, v3, v4;
  logic [2:0][VW-1:0]        m1, m2;
  logic [2:0]                neg1, neg2;
  logic [BLW-1:0]            bl2;
  logic                      deg2;
  snu_pkg::snu_side_t        side3, side4;
  logic [2:0][2*NB-1:0]      sq4;

  logic [VW-1:0]             mor;
  logic [BLW-1:0]            blc;
  snu_pkg::snu_side_t        side_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      sum_valid <= 1'b0;
    end else if (en) begin
      v1        <= vec_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      sum_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= vec[i][VW-1];
        m1[i]   <= vec[i][VW-1] ? VW'(-vec[i]) : vec[i];
      end
    end
  end

  always_comb begin
    mor = m1[0] | m1[1] | m1[2];
    blc = '0;
    for (int j = 0; j < VW; j++) begin
      if (mor[j]) blc = BLW'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2   <= m1;
      neg2 <= neg1;
      bl2  <= blc;
      deg2 <= (mor == '0);
    end
  end

  always_comb begin
    side_c.flags.deg = deg2;
    side_c.flags.neg = neg2;
    for (int i = 0; i < 3; i++) begin
      side_c.mag[i] = NB'({m2[i], NB'(0)} >> bl2);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side_c;
      side4 <= side3;
      side  <= side4;
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= (2*NB)'(side3.mag[i] * side3.mag[i]);
      end
      sum <= SW'(sq4[0]) + SW'(sq4[1]) + SW'(sq4[2]);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/snu_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module snu_sqrt (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                sum_valid,
  input  wire logic [snu_pkg::SUM_WIDTH-1:0]       sum,
  input  snu_pkg::snu_side_t                       side_in,
  output logic                                     root_valid,
  output logic [snu_pkg::ROOT_WIDTH-1:0]           root,
  output snu_pkg::snu_side_t                       side_out
);

  localparam int RW = snu_pkg::ROOT_WIDTH;
  localparam int SW = snu_pkg::SUM_WIDTH;

  logic                 st_v    [0:RW];
  logic [SW-1:0]        st_x    [0:RW];
  logic [RW+1:0]        st_rem  [0:RW];
  logic [RW-1:0]        st_root [0:RW];
  snu_pkg::snu_side_t   st_side [0:RW];

  assign st_v[0]    = sum_valid;
  assign st_x[0]    = sum;
  assign st_rem[0]  = '0;
  assign st_root[0] = '0;
  assign st_side[0] = side_in;

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int P = RW - 1 - g;
    logic [RW+1:0] remc;
    logic [RW+1:0] trial;
    logic          ge;

    always_comb begin
      remc  = {st_rem[g][RW-1:0], st_x[g][2*P+1 -: 2]};
      trial = {st_root[g], 2'b01};
      ge    = (remc >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[g+1] <= 1'b0;
      end else if (en) begin
        st_v[g+1] <= st_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_x[g+1]    <= st_x[g];
        st_side[g+1] <= st_side[g];
        st_rem[g+1]  <= ge ? remc - trial : remc;
        st_root[g+1] <= {st_root[g][RW-2:0], ge};
      end
    end
  end

  assign root_valid = st_v[RW];
  assign root       = st_root[RW];
  assign side_out   = st_side[RW];

endmodule
`default_nettype wire

>>> rtl/core/snu_div.sv
// Pipelined rounded divide of each magnitude by the root, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module snu_div #(
  parameter int OFB = 14
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                root_valid,
  input  wire logic [snu_pkg::ROOT_WIDTH-1:0]      root,
  input  snu_pkg::snu_side_t                       side,
  output logic                                     q_valid,
  output logic [2:0][OFB:0]                        q,
  output snu_pkg::snu_flags_t                      flags
);

  localparam int QW  = OFB + 1;
  localparam int NB  = snu_pkg::NORM_BITS;
  localparam int RW  = snu_pkg::ROOT_WIDTH;
  localparam int DW  = RW + 1;
  localparam int NW  = NB + QW + 1;
  localparam int RMW = DW + 1;

  logic                  st_v     [0:QW];
  logic [2:0][NW-1:0]    st_n     [0:QW];
  logic [DW-1:0]         st_d     [0:QW];
  logic [2:0][RMW-1:0]   st_rem   [0:QW];
  logic [2:0][QW-1:0]    st_q     [0:QW];
  snu_pkg::snu_flags_t   st_flags [0:QW];

  logic [2:0][NW-1:0]    nc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nc[i] = NW'({side.mag[i], QW'(0)}) + NW'(root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (en) begin
      st_v[0] <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_d[0]     <= {root, 1'b0};
      st_flags[0] <= side.flags;
      st_q[0]     <= '0;
      for (int i = 0; i < 3; i++) begin
        st_n[0][i]   <= nc[i];
        st_rem[0][i] <= RMW'(nc[i][NW-1:QW]);
      end
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic [2:0][RMW-1:0] remc;
    logic [2:0]          ge;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        remc[i] = {st_rem[j][i][RMW-2:0], st_n[j][i][B]};
        ge[i]   = (remc[i] >= RMW'(st_d[j]));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j+1] <= 1'b0;
      end else if (en) begin
        st_v[j+1] <= st_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_n[j+1]     <= st_n[j];
        st_d[j+1]     <= st_d[j];
        st_flags[j+1] <= st_flags[j];
        for (int i = 0; i < 3; i++) begin
          st_rem[j+1][i] <= ge[i] ? remc[i] - RMW'(st_d[j]) : remc[i];
          st_q[j+1][i]   <= {st_q[j][i][QW-2:0], ge[i]};
        end
      end
    end
  end

  assign q_valid = st_v[QW];
  assign q       = st_q[QW];
  assign flags   = st_flags[QW];

endmodule
`default_nettype wire

>>> rtl/core/surface_normal_unit.sv
// Top level of the surface normal unit: unit vector or unit triangle normal.
//
//   channel  direction  handshake            payload
//   input    in         in_valid / in_stall  command, ax..cz
//   output   out        out_valid / out_stall nx, ny, nz, degenerate
//
// One transfer per cycle in each direction when not stalled.
// Stages in order: cross product, normalize and sum of squares, square root,
// divide, output.
// Reset clears all valid bits; payload registers are not reset.
// A stall while out_valid is high freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module surface_normal_unit #(
  parameter int COORD_WIDTH   = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                command,
  input  wire logic signed [COORD_WIDTH-1:0]       ax,
  input  wire logic signed [COORD_WIDTH-1:0]       ay,
  input  wire logic signed [COORD_WIDTH-1:0]       az,
  input  wire logic signed [COORD_WIDTH-1:0]       bx,
  input  wire logic signed [COORD_WIDTH-1:0]       by_coord,
  input  wire logic signed [COORD_WIDTH-1:0]       bz,
  input  wire logic signed [COORD_WIDTH-1:0]       cx,
  input  wire logic signed [COORD_WIDTH-1:0]       cy,
  input  wire logic signed [COORD_WIDTH-1:0]       cz,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [snu_pkg::OUT_WIDTH-1:0]     nx,
  output logic signed [snu_pkg::OUT_WIDTH-1:0]     ny,
  output logic signed [snu_pkg::OUT_WIDTH-1:0]     nz,
  output logic                                     degenerate
);

  localparam int VW = snu_pkg::vec_width(COORD_WIDTH);
  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int OW = snu_pkg::OUT_WIDTH;

  logic                                en;
  logic [2:0][COORD_WIDTH-1:0]         pa, pb, pc;
  logic                                vec_valid;
  logic [2:0][VW-1:0]                  vec;
  logic                                sum_valid;
  logic [snu_pkg::SUM_WIDTH-1:0]       sum;
  snu_pkg::snu_side_t                  side_n;
  logic                                root_valid;
  logic [snu_pkg::ROOT_WIDTH-1:0]      root;
  snu_pkg::snu_side_t                  side_r;
  logic                                q_valid;
  logic [2:0][QW-1:0]                  q;
  snu_pkg::snu_flags_t                 flags;
  logic [2:0][31:0]                    res;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign pa = {az, ay, ax};
  assign pb = {bz, by_coord, bx};
  assign pc = {cz, cy, cx};

  snu_cross #(.CW(COORD_WIDTH), .VW(VW)) u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .command   (command),
    .a         (pa),
    .b         (pb),
    .c         (pc),
    .vec_valid (vec_valid),
    .vec       (vec)
  );

  snu_prenorm #(.VW(VW)) u_prenorm (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .vec_valid (vec_valid),
    .vec       (vec),
    .sum_valid (sum_valid),
    .sum       (sum),
    .side      (side_n)
  );

  snu_sqrt u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .sum_valid  (sum_valid),
    .sum        (sum),
    .side_in    (side_n),
    .root_valid (root_valid),
    .root       (root),
    .side_out   (side_r)
  );

  snu_div #(.OFB(OUT_FRAC_BITS)) u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .root_valid (root_valid),
    .root       (root),
    .side       (side_r),
    .q_valid    (q_valid),
    .q          (q),
    .flags      (flags)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res[i] = flags.neg[i] ? -32'(q[i]) : 32'(q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      degenerate <= flags.deg;
      nx <= flags.deg ? '0 : res[0][OW-1:0];
      ny <= flags.deg ? '0 : res[1][OW-1:0];
      nz <= flags.deg ? '0 : res[2][OW-1:0];
    end
  end

endmodule
`default_nettype wire

>>> sim/surface_normal_unit_test.sv
// Self-checking testbench for the surface normal unit: random and corner triangles and vectors.
`timescale 1ns / 1ps
module surface_normal_unit_test;

  localparam int CW = 16;
  localparam int FB = 14;
  localparam bit CMD_VECTOR = 1'b0;
  localparam bit CMD_TRIANGLE = 1'b1;
  localparam int LATENCY = 37 + FB;

  typedef struct {
    bit command;
    logic signed [CW-1:0] p [9];
  } shape_t;

  typedef struct {
    logic signed [snu_pkg::OUT_WIDTH-1:0] n [3];
    bit deg;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = 1'b0;
  logic signed [CW-1:0] ax = '0, ay = '0, az = '0, bx = '0, by_coord = '0, bz = '0;
  logic signed [CW-1:0] cx = '0, cy = '0, cz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [snu_pkg::OUT_WIDTH-1:0] nx, ny, nz;
  logic degenerate;

  shape_t pending_shapes[$];
  normal_t expected_normals[$];
  int errors = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  surface_normal_unit #(.COORD_WIDTH(CW), .OUT_FRAC_BITS(FB)) i_dut (
    .clk, .rst, .in_valid, .in_stall, .command, .ax, .ay, .az, .bx, .by_coord, .bz,
    .cx, .cy, .cz, .out_valid, .out_stall, .nx, .ny, .nz, .degenerate
  );

  always #5 clk = ~clk;

  function automatic int bit_length(longint unsigned x);
    int len;
    len = 0;
    while (x != 0) begin
      len++;
      x >>= 1;
    end
    return len;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic normal_t unit_normal(shape_t s);
    normal_t res;
    longint v[3], e1[3], e2[3];
    longint unsigned m[3], mx, sum, root, q;
    int len;
    mx = 0;
    sum = 0;
    if (s.command == CMD_VECTOR) begin
      for (int i = 0; i < 3; i++) v[i] = s.p[i];
    end else begin
      for (int i = 0; i < 3; i++) begin
        e1[i] = longint'(s.p[3+i]) - longint'(s.p[i]);
        e2[i] = longint'(s.p[6+i]) - longint'(s.p[i]);
      end
      v[0] = e1[1] * e2[2] - e1[2] * e2[1];
      v[1] = e1[2] * e2[0] - e1[0] * e2[2];
      v[2] = e1[0] * e2[1] - e1[1] * e2[0];
    end
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    res.deg = (mx == 0);
    for (int i = 0; i < 3; i++) res.n[i] = '0;
    if (res.deg) return res;
    len = bit_length(mx);
    for (int i = 0; i < 3; i++) begin
      if (len < snu_pkg::NORM_BITS) m[i] <<= (snu_pkg::NORM_BITS - len);
      else if (len > snu_pkg::NORM_BITS) m[i] >>= (len - snu_pkg::NORM_BITS);
      sum += m[i] * m[i];
    end
    root = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (FB + 1)) + root) / (2 * root);
      res.n[i] = v[i] < 0 ? -q : q;
    end
    return res;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
      2: return $signed(16'($urandom_range(0, 512))) - 16'sd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_shape(bit cmd, logic signed [CW-1:0] p0, p1, p2, p3, p4, p5,
                           p6, p7, p8);
    shape_t s;
    s.command = cmd;
    s.p = '{p0, p1, p2, p3, p4, p5, p6, p7, p8};
    pending_shapes.push_back(s);
  endtask

  always @(posedge clk) begin
    shape_t s;
    shape_t seen;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        seen.command = command;
        seen.p = '{ax, ay, az, bx, by_coord, bz, cx, cy, cz};
        expected_normals.push_back(unit_normal(seen));
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_shapes.size() > 0) begin
          s = pending_shapes.pop_front();
          in_valid <= 1'b1;
          command <= s.command;
          ax <= s.p[0]; ay <= s.p[1]; az <= s.p[2];
          bx <= s.p[3]; by_coord <= s.p[4]; bz <= s.p[5];
          cx <= s.p[6]; cy <= s.p[7]; cz <= s.p[8];
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    normal_t e;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_normals.size() == 0) begin
          $error("unexpected transfer nx=%0d ny=%0d nz=%0d", nx, ny, nz);
          errors++;
        end else begin
          e = expected_normals.pop_front();
          if (nx !== e.n[0]) begin $error("nx exp %0d got %0d", e.n[0], nx); errors++; end
          if (ny !== e.n[1]) begin $error("ny exp %0d got %0d", e.n[1], ny); errors++; end
          if (nz !== e.n[2]) begin $error("nz exp %0d got %0d", e.n[2], nz); errors++; end
          if (degenerate !== e.deg) begin
            $error("degenerate exp %0d got %0d", e.deg, degenerate);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(5, 60);
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        2: out_stall <= $urandom_range(0, 1);
        default: out_stall <= $urandom_range(0, 5) != 0;
      endcase
    end
  end

  initial begin
    logic signed [CW-1:0] r[9];
    add_shape(CMD_VECTOR, 0, 0, 0, 1, 2, 3, 4, 5, 6);
    add_shape(CMD_VECTOR, 16'sh7fff, 16'sh7fff, 16'sh7fff, 0, 0, 0, 0, 0, 0);
    add_shape(CMD_VECTOR, 16'sh8000, 16'sh8000, 16'sh8000, -1, -1, -1, -1, -1, -1);
    add_shape(CMD_VECTOR, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_shape(CMD_VECTOR, 0, -1, 0, 0, 0, 0, 0, 0, 0);
    add_shape(CMD_VECTOR, 0, 0, 16'sh8000, 0, 0, 0, 0, 0, 0);
    add_shape(CMD_VECTOR, 3, -4, 0, 0, 0, 0, 0, 0, 0);
    add_shape(CMD_VECTOR, 16'sh7fff, 1, -1, 0, 0, 0, 0, 0, 0);
    add_shape(CMD_TRIANGLE, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    add_shape(CMD_TRIANGLE, 0, 0, 0, 0, 256, 0, 256, 0, 0);
    add_shape(CMD_TRIANGLE, 5, 5, 5, 5, 5, 5, 5, 5, 5);
    add_shape(CMD_TRIANGLE, 0, 0, 0, 1, 1, 1, 2, 2, 2);
    add_shape(CMD_TRIANGLE, 0, 0, 0, 16'sh7fff, 0, 0, 0, 0, 0);
    add_shape(CMD_TRIANGLE, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000);
    add_shape(CMD_TRIANGLE, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    add_shape(CMD_TRIANGLE, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
              16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000);
    add_shape(CMD_TRIANGLE, 0, 0, 0, 1, 0, 0, 0, 1, 0);
    add_shape(CMD_TRIANGLE, 0, 0, 0, 16'sh7fff, 16'sh7fff, 0, 16'sh8000, 16'sh8000, 0);
    for (int k = 0; k < 1450; k++) begin
      for (int i = 0; i < 9; i++) r[i] = rand_coord();
      if ($urandom_range(0, 19) == 0)
        for (int i = 0; i < 3; i++) r[6+i] = r[3+i];
      add_shape(1'($urandom), r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_shapes.size() == 0 && !in_valid);
    wait (expected_normals.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/snu_pkg.sv
rtl/core/snu_cross.sv
rtl/core/snu_prenorm.sv
rtl/core/snu_sqrt.sv
rtl/core/snu_div.sv
rtl/core/surface_normal_unit.sv
sim/surface_normal_unit_test.sv
